// ===== design/masked_header_signature_matcher_assert.svh =====
// Assertion macros for the masked header signature matcher.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef MASKED_HEADER_SIGNATURE_MATCHER_ASSERT_SVH
`define MASKED_HEADER_SIGNATURE_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define MHSM_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MHSM_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MHSM_AST_IMP(lbl, ante, cons)
`define MHSM_AST_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/mhsm_pkg.sv =====
// Shared types and constants for the masked header signature matcher.
// No dependencies; used by mhsm_lane and the top level.
`default_nettype none

package mhsm_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_OFFSET_DEF  = 255;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_WRITE  = 2'd2,
    OP_HEADER = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_MATCH   = 3'd4
  } status_t;

  // Broadcast control from the top level to every signature lane.
  typedef struct packed {
    logic       drop;
    logic       hdr;
    logic [7:0] data;
    logic [2:0] wr_pos;
    logic [7:0] wr_pat;
    logic [7:0] wr_mask;
    logic [3:0] add_len;
    logic [7:0] add_start;
    logic [6:0] add_conf;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== design/mhsm_lane.sv =====
// One signature slot: pattern and mask row, span check and masked compare.
// Depends on mhsm_pkg for the lane control struct.
`default_nettype none

module mhsm_lane #(
  parameter int MAX_PATTERN = mhsm_pkg::MAX_PATTERN_DEF,
  parameter int CNT_W       = 9,
  parameter int LEN_W       = 4,
  parameter int POS_W       = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  mhsm_pkg::lane_ctl_t    ctl,
  input  wire logic              add_sel,
  input  wire logic              wr_sel,
  input  wire logic              active,
  input  wire logic [CNT_W-1:0]  cnt,
  input  wire logic [CNT_W-1:0]  cnt_inc,
  output logic [6:0]             cand_conf,
  output logic [7:0]             sig_start,
  output logic [LEN_W-1:0]       sig_len
);

  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  logic [7:0]             pat_r  [MAX_PATTERN];
  logic [7:0]             mask_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mvld_r;
  logic [LEN_W-1:0]       len_r;
  logic [7:0]             start_r;
  logic [6:0]             conf_r;
  logic                   mis_r;

  logic [CMP_W-1:0]   p_ext, pi_ext, s_ext, l_ext, end_ext, k;
  logic [POS_W-1:0]   rd_idx, wr_idx;
  logic [POS_W+2:0]   wr_pos_ext;
  logic [LEN_W+3:0]   add_len_ext;
  logic [7:0]         mask_eff;
  logic               in_span, byte_mis, mis_now, end_ok;

  assign p_ext   = {{(CMP_W-CNT_W){1'b0}}, cnt};
  assign pi_ext  = {{(CMP_W-CNT_W){1'b0}}, cnt_inc};
  assign s_ext   = {{(CMP_W-8){1'b0}}, start_r};
  assign l_ext   = {{(CMP_W-LEN_W){1'b0}}, len_r};
  assign end_ext = s_ext + l_ext;
  assign k       = p_ext - s_ext;
  assign rd_idx  = k[POS_W-1:0];

  assign wr_pos_ext  = {{POS_W{1'b0}}, ctl.wr_pos};
  assign wr_idx      = wr_pos_ext[POS_W-1:0];
  assign add_len_ext = {{LEN_W{1'b0}}, ctl.add_len};

  always_comb begin
    in_span  = active && (p_ext >= s_ext) && (p_ext < end_ext);
    // A mask byte that was never written since the add reads as all ones.
    mask_eff = mvld_r[rd_idx] ? mask_r[rd_idx] : 8'hFF;
    byte_mis = in_span && (((ctl.data ^ pat_r[rd_idx]) & mask_eff) != 8'h00);
    mis_now  = mis_r || byte_mis;
    end_ok   = end_ext <= pi_ext;
    cand_conf = (active && !mis_now && end_ok) ? conf_r : 7'd0;
  end

  assign sig_start = start_r;
  assign sig_len   = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mis_r  <= 1'b0;
      mvld_r <= '0;
    end else begin
      if (ctl.drop) begin
        mis_r <= 1'b0;
      end else if (ctl.hdr) begin
        mis_r <= mis_now;
      end
      if (add_sel) begin
        mvld_r <= '0;
      end else if (wr_sel) begin
        mvld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_sel) begin
      len_r   <= add_len_ext[LEN_W-1:0];
      start_r <= ctl.add_start;
      conf_r  <= ctl.add_conf;
    end
    if (wr_sel) begin
      pat_r[wr_idx]  <= ctl.wr_pat;
      mask_r[wr_idx] <= ctl.wr_mask;
    end
  end

endmodule

`default_nettype wire

// ===== design/masked_header_signature_matcher.sv =====
// Top level of the masked header signature matcher.
// Depends on mhsm_pkg, mhsm_lane and masked_header_signature_matcher_assert.svh.
//
// Usage: an item is taken at a rising edge with start high and busy low. The
// opcode picks clear table, add signature, write pattern byte or header byte.
// An add answers with added, table full or bad length and the assigned slot.
// Header bytes stream in one per item; the item with last_byte set answers
// with the best match (highest confidence, earliest slot on ties) or no match.
// Clear and pattern writes give no result, and any of them, or an add, drops a
// header in progress.
// The out_valid flag rises at the edge after the one that takes the item (input
// register, then result register). Throughput is one item per cycle while busy
// is low; every slot compares in parallel and a comparator tree picks the
// winner within the result stage.
// Reset (synchronous, active low) empties the table, drops any header, and
// holds busy high until the first edge after rst_n rises. The receiver
// cannot stall: each result is on the out_ ports for exactly one cycle.
`default_nettype none
`include "masked_header_signature_matcher_assert.svh"

module masked_header_signature_matcher #(
  parameter int MAX_ENTRIES = mhsm_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_PATTERN = mhsm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_OFFSET  = mhsm_pkg::MAX_OFFSET_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_opcode,
  input  wire logic [3:0] in_entry_slot,
  input  wire logic [2:0] in_byte_position,
  input  wire logic [7:0] in_pattern_byte,
  input  wire logic [7:0] in_mask_byte,
  input  wire logic [3:0] in_pattern_length,
  input  wire logic [7:0] in_start_offset,
  input  wire logic [6:0] in_confidence_level,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  output logic [2:0]      out_result_status,
  output logic [3:0]      out_matched_entry,
  output logic [6:0]      out_matched_confidence,
  output logic [7:0]      out_matched_offset,
  output logic [3:0]      out_matched_length
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int POS_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CAP    = MAX_OFFSET + MAX_PATTERN;
  localparam int CNT_W  = (CAP > 0) ? $clog2(CAP + 1) : 1;
  localparam int NODES  = 1 << $clog2(MAX_ENTRIES);

  // Input register.
  logic                busy_r;
  logic                ivld_r;
  mhsm_pkg::op_t       op_r;
  logic [3:0]          slot_r;
  logic [2:0]          pos_r;
  logic [7:0]          pat_r, mask_r, start_r, data_r;
  logic [3:0]          len_r;
  logic [6:0]          conf_r;
  logic                last_r;

  // Block state.
  logic [ECNT_W-1:0]   ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0]    bcnt_r, bcnt_nxt, bcnt_inc;

  // Result register.
  logic                ovld_r, ovld_nxt;
  mhsm_pkg::status_t   ost_r, ost_nxt;
  logic [3:0]          oent_r, oent_nxt;
  logic [6:0]          oconf_r, oconf_nxt;
  logic [7:0]          ooff_r, ooff_nxt;
  logic [3:0]          olen_r, olen_nxt;

  logic                is_clr, is_add, is_wr, is_hdr;
  logic                bad_len, tbl_full, add_ok, wr_ok, hdr_last;
  mhsm_pkg::lane_ctl_t ctl;

  logic [MAX_ENTRIES-1:0] add_sel, wr_sel, active;
  logic [6:0]             lane_conf  [MAX_ENTRIES];
  logic [7:0]             lane_start [MAX_ENTRIES];
  logic [LEN_W-1:0]       lane_len   [MAX_ENTRIES];

  logic [6:0]             node_conf [2*NODES-1];
  logic [IDX_W-1:0]       node_idx  [2*NODES-1];

  logic [IDX_W-1:0]       best_idx;
  logic [6:0]             best_conf;
  logic [IDX_W+3:0]       best_idx_ext;
  logic [LEN_W+3:0]       best_len_ext;
  logic [ECNT_W+3:0]      add_slot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ivld_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      ivld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      op_r    <= mhsm_pkg::op_t'(in_opcode);
      slot_r  <= in_entry_slot;
      pos_r   <= in_byte_position;
      pat_r   <= in_pattern_byte;
      mask_r  <= in_mask_byte;
      len_r   <= in_pattern_length;
      start_r <= in_start_offset;
      conf_r  <= in_confidence_level;
      data_r  <= in_data_byte;
      last_r  <= in_last_byte;
    end
  end

  always_comb begin
    is_clr = 1'b0;
    is_add = 1'b0;
    is_wr  = 1'b0;
    is_hdr = 1'b0;
    unique case (op_r)
      mhsm_pkg::OP_CLEAR:  is_clr = ivld_r;
      mhsm_pkg::OP_ADD:    is_add = ivld_r;
      mhsm_pkg::OP_WRITE:  is_wr  = ivld_r;
      mhsm_pkg::OP_HEADER: is_hdr = ivld_r;
      default:             is_clr = 1'b0;
    endcase
  end

  always_comb begin
    bad_len  = (len_r == 4'd0) || ({1'b0, len_r} > 5'(MAX_PATTERN)) ||
               ({5'd0, start_r} > 13'(MAX_OFFSET));
    tbl_full = ecnt_r == ECNT_W'(MAX_ENTRIES);
    add_ok   = is_add && !bad_len && !tbl_full;
    wr_ok    = is_wr && ({3'd0, slot_r} < 7'(MAX_ENTRIES)) &&
               ({2'd0, pos_r} < 5'(MAX_PATTERN));
    hdr_last = is_hdr && last_r;
    bcnt_inc = (bcnt_r < CNT_W'(CAP)) ? bcnt_r + 1'b1 : bcnt_r;

    ctl.drop      = is_clr || is_add || is_wr || hdr_last;
    ctl.hdr       = is_hdr;
    ctl.data      = data_r;
    ctl.wr_pos    = pos_r;
    ctl.wr_pat    = pat_r;
    ctl.wr_mask   = mask_r;
    ctl.add_len   = len_r;
    ctl.add_start = start_r;
    ctl.add_conf  = conf_r;

    if (is_clr) begin
      ecnt_nxt = '0;
    end else if (add_ok) begin
      ecnt_nxt = ecnt_r + 1'b1;
    end else begin
      ecnt_nxt = ecnt_r;
    end

    if (ctl.drop) begin
      bcnt_nxt = '0;
    end else if (is_hdr) begin
      bcnt_nxt = bcnt_inc;
    end else begin
      bcnt_nxt = bcnt_r;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_lane
    assign add_sel[i] = add_ok && (ecnt_r == ECNT_W'(i));
    assign wr_sel[i]  = wr_ok && ({3'd0, slot_r} == 7'(i));
    assign active[i]  = ECNT_W'(i) < ecnt_r;

    mhsm_lane #(
      .MAX_PATTERN (MAX_PATTERN),
      .CNT_W       (CNT_W),
      .LEN_W       (LEN_W),
      .POS_W       (POS_W)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .add_sel   (add_sel[i]),
      .wr_sel    (wr_sel[i]),
      .active    (active[i]),
      .cnt       (bcnt_r),
      .cnt_inc   (bcnt_inc),
      .cand_conf (lane_conf[i]),
      .sig_start (lane_start[i]),
      .sig_len   (lane_len[i])
    );
  end

  // Max-confidence tree; the left (lower slot) side keeps ties, and a
  // confidence of zero marks no candidate.
  for (genvar i = 0; i < NODES; i++) begin : g_leaf
    if (i < MAX_ENTRIES) begin : g_real
      assign node_conf[NODES-1+i] = lane_conf[i];
      assign node_idx[NODES-1+i]  = IDX_W'(i);
    end else begin : g_pad
      assign node_conf[NODES-1+i] = 7'd0;
      assign node_idx[NODES-1+i]  = '0;
    end
  end

  for (genvar j = 0; j < NODES - 1; j++) begin : g_node
    assign node_conf[j] = (node_conf[2*j+2] > node_conf[2*j+1]) ?
                          node_conf[2*j+2] : node_conf[2*j+1];
    assign node_idx[j]  = (node_conf[2*j+2] > node_conf[2*j+1]) ?
                          node_idx[2*j+2] : node_idx[2*j+1];
  end

  assign best_idx     = node_idx[0];
  assign best_conf    = node_conf[0];
  assign best_idx_ext = {4'd0, best_idx};
  assign best_len_ext = {4'd0, lane_len[best_idx]};
  assign add_slot_ext = {4'd0, ecnt_r};

  always_comb begin
    ovld_nxt  = is_add || hdr_last;
    ost_nxt   = mhsm_pkg::ST_NOMATCH;
    oent_nxt  = 4'd0;
    oconf_nxt = 7'd0;
    ooff_nxt  = 8'd0;
    olen_nxt  = 4'd0;
    priority if (is_add && bad_len) begin
      ost_nxt = mhsm_pkg::ST_BADLEN;
    end else if (is_add && tbl_full) begin
      ost_nxt = mhsm_pkg::ST_FULL;
    end else if (is_add) begin
      ost_nxt  = mhsm_pkg::ST_ADDED;
      oent_nxt = add_slot_ext[3:0];
    end else if (best_conf != 7'd0) begin
      ost_nxt   = mhsm_pkg::ST_MATCH;
      oent_nxt  = best_idx_ext[3:0];
      oconf_nxt = best_conf;
      ooff_nxt  = lane_start[best_idx];
      olen_nxt  = best_len_ext[3:0];
    end else begin
      ost_nxt = mhsm_pkg::ST_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      bcnt_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      ecnt_r <= ecnt_nxt;
      bcnt_r <= bcnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ost_r   <= ost_nxt;
    oent_r  <= oent_nxt;
    oconf_r <= oconf_nxt;
    ooff_r  <= ooff_nxt;
    olen_r  <= olen_nxt;
  end

  assign busy                   = busy_r;
  assign out_valid              = ovld_r;
  assign out_result_status      = ost_r;
  assign out_matched_entry      = oent_r;
  assign out_matched_confidence = oconf_r;
  assign out_matched_offset     = ooff_r;
  assign out_matched_length     = olen_r;

  `MHSM_AST_NXT(a_add_answers, is_add, ovld_r)
  `MHSM_AST_NXT(a_write_silent, is_wr || is_clr || (is_hdr && !last_r), !ovld_r)
  `MHSM_AST_IMP(a_match_conf, ovld_r && (ost_r == mhsm_pkg::ST_MATCH), oconf_r != 7'd0)
  `MHSM_AST_IMP(a_count_bound, 1'b1, ecnt_r <= ECNT_W'(MAX_ENTRIES))
  `MHSM_AST_NXT(a_drop_clears, ctl.drop, bcnt_r == '0)

endmodule

`default_nettype wire

// ===== sim/mhsm_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the masked header signature matcher: watches the item and
// result ports, keeps its own copy of the signature table and compares every result.
// Depends on mhsm_pkg.
module mhsm_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_entry_slot,
  input  logic [2:0] in_byte_position,
  input  logic [7:0] in_pattern_byte,
  input  logic [7:0] in_mask_byte,
  input  logic [3:0] in_pattern_length,
  input  logic [7:0] in_start_offset,
  input  logic [6:0] in_confidence_level,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic [2:0] out_result_status,
  input  logic [3:0] out_matched_entry,
  input  logic [6:0] out_matched_confidence,
  input  logic [7:0] out_matched_offset,
  input  logic [3:0] out_matched_length,
  output int         mismatch_count,
  output int         pending_count
);

  localparam int SLOTS     = mhsm_pkg::MAX_ENTRIES_DEF;
  localparam int PAT       = mhsm_pkg::MAX_PATTERN_DEF;
  localparam int COUNT_CAP = mhsm_pkg::MAX_OFFSET_DEF + mhsm_pkg::MAX_PATTERN_DEF;

  typedef struct packed {
    mhsm_pkg::status_t status;
    logic [3:0]        entry;
    logic [6:0]        conf;
    logic [7:0]        offs;
    logic [3:0]        len;
  } report_t;

  int               table_count;
  int               sig_len[SLOTS];
  int               sig_off[SLOTS];
  int               sig_conf[SLOTS];
  logic [7:0]       pat_mem[SLOTS*PAT];
  logic [7:0]       mask_mem[SLOTS*PAT];
  logic [SLOTS-1:0] miss;
  int               hdr_pos;
  report_t          awaited_reports[$];
  report_t          want;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic push_report(mhsm_pkg::status_t st, int entry, int conf, int offs, int len);
    report_t r;
    r.status = st;
    r.entry  = 4'(entry);
    r.conf   = 7'(conf);
    r.offs   = 8'(offs);
    r.len    = 4'(len);
    awaited_reports.push_back(r);
  endtask

  task automatic drop_header();
    miss    = '0;
    hdr_pos = 0;
  endtask

  task automatic clear_table_copy();
    int i;
    table_count = 0;
    for (i = 0; i < SLOTS; i++) begin
      sig_len[i]  = 0;
      sig_off[i]  = 0;
      sig_conf[i] = 0;
    end
    for (i = 0; i < SLOTS*PAT; i++) begin
      pat_mem[i]  = 8'h00;
      mask_mem[i] = 8'hFF;
    end
    drop_header();
    awaited_reports.delete();
  endtask

  // Applies one accepted item to the table copy and queues the result it causes.
  task automatic advance_table();
    int i, k, idx, best, best_conf;
    bit found;
    case (mhsm_pkg::op_t'(in_opcode))
      mhsm_pkg::OP_CLEAR: begin
        table_count = 0;
        drop_header();
      end
      mhsm_pkg::OP_ADD: begin
        drop_header();
        if (in_pattern_length == 0 || in_pattern_length > PAT) begin
          push_report(mhsm_pkg::ST_BADLEN, 0, 0, 0, 0);
        end else if (table_count >= SLOTS) begin
          push_report(mhsm_pkg::ST_FULL, 0, 0, 0, 0);
        end else begin
          sig_len[table_count]  = in_pattern_length;
          sig_off[table_count]  = in_start_offset;
          sig_conf[table_count] = in_confidence_level;
          for (k = 0; k < PAT; k++) mask_mem[table_count*PAT + k] = 8'hFF;
          push_report(mhsm_pkg::ST_ADDED, table_count, 0, 0, 0);
          table_count++;
        end
      end
      mhsm_pkg::OP_WRITE: begin
        drop_header();
        idx = int'(in_entry_slot) * PAT + int'(in_byte_position);
        pat_mem[idx]  = in_pattern_byte;
        mask_mem[idx] = in_mask_byte;
      end
      mhsm_pkg::OP_HEADER: begin
        for (i = 0; i < table_count; i++) begin
          if (hdr_pos >= sig_off[i] && hdr_pos < sig_off[i] + sig_len[i]) begin
            idx = i * PAT + hdr_pos - sig_off[i];
            if (((in_data_byte ^ pat_mem[idx]) & mask_mem[idx]) != 8'h00) miss[i] = 1'b1;
          end
        end
        if (hdr_pos < COUNT_CAP) hdr_pos++;
        if (in_last_byte) begin
          found     = 1'b0;
          best      = 0;
          best_conf = 0;
          // Strictly greater keeps the earliest slot on ties and lets zero never win.
          for (i = 0; i < table_count; i++) begin
            if (!miss[i] && sig_off[i] + sig_len[i] <= hdr_pos && sig_conf[i] > best_conf) begin
              best      = i;
              best_conf = sig_conf[i];
              found     = 1'b1;
            end
          end
          if (found) begin
            push_report(mhsm_pkg::ST_MATCH, best, sig_conf[best], sig_off[best],
                        sig_len[best]);
          end else begin
            push_report(mhsm_pkg::ST_NOMATCH, 0, 0, 0, 0);
          end
          drop_header();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table_copy();
    end else begin
      if (out_valid !== 1'b0) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch("unexpected result, status", out_result_status, 0);
        end else begin
          want = awaited_reports.pop_front();
          if (out_result_status !== want.status)
            report_mismatch("status", out_result_status, want.status);
          if (out_matched_entry !== want.entry)
            report_mismatch("entry", out_matched_entry, want.entry);
          if (out_matched_confidence !== want.conf)
            report_mismatch("confidence", out_matched_confidence, want.conf);
          if (out_matched_offset !== want.offs)
            report_mismatch("offset", out_matched_offset, want.offs);
          if (out_matched_length !== want.len)
            report_mismatch("length", out_matched_length, want.len);
        end
      end
      if (start && !busy) advance_table();
    end
    pending_count = awaited_reports.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the masked header signature matcher testbench: clock, reset and item
// stimulus, with mhsm_checker beside the block. Depends on mhsm_pkg and the block.
module testbench;

  localparam int SLOTS       = mhsm_pkg::MAX_ENTRIES_DEF;
  localparam int PAT         = mhsm_pkg::MAX_PATTERN_DEF;
  localparam int ITEM_TARGET = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    mhsm_pkg::op_t op;
    logic [3:0]    slot;
    logic [2:0]    pos;
    logic [7:0]    pat;
    logic [7:0]    mask;
    logic [3:0]    len;
    logic [7:0]    offs;
    logic [6:0]    conf;
    logic [7:0]    data;
    logic          last;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_entry_slot = '0;
  logic [2:0] in_byte_position = '0;
  logic [7:0] in_pattern_byte = '0;
  logic [7:0] in_mask_byte = '0;
  logic [3:0] in_pattern_length = '0;
  logic [7:0] in_start_offset = '0;
  logic [6:0] in_confidence_level = '0;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic [2:0] out_result_status;
  logic [3:0] out_matched_entry;
  logic [6:0] out_matched_confidence;
  logic [7:0] out_matched_offset;
  logic [3:0] out_matched_length;
  int         mismatch_count;
  int         pending_count;

  // What the stimulus knows of the table, so headers can be built to match.
  int         m_count;
  int         m_len[SLOTS];
  int         m_off[SLOTS];
  logic [7:0] m_pat[SLOTS*PAT];
  logic [7:0] m_mask[SLOTS*PAT];
  bit         m_written[SLOTS*PAT];
  bit         burst;
  int         items_sent;
  int         cycles;

  int         dir_len[3]  = '{8, 1, 2};
  int         dir_off[3]  = '{0, 255, 1};
  int         dir_conf[3] = '{100, 0, 100};
  logic [7:0] dir_pat[8]  = '{8'h00, 8'h5A, 8'hC3, 8'h3C, 8'hFF, 8'h81, 8'h7E, 8'hA5};
  logic [7:0] dir_mask[8] = '{8'hFF, 8'h00, 8'h0F, 8'hF0, 8'hFF, 8'h80, 8'h01, 8'hFF};

  masked_header_signature_matcher dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_entry_slot         (in_entry_slot),
    .in_byte_position      (in_byte_position),
    .in_pattern_byte       (in_pattern_byte),
    .in_mask_byte          (in_mask_byte),
    .in_pattern_length     (in_pattern_length),
    .in_start_offset       (in_start_offset),
    .in_confidence_level   (in_confidence_level),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_result_status     (out_result_status),
    .out_matched_entry     (out_matched_entry),
    .out_matched_confidence(out_matched_confidence),
    .out_matched_offset    (out_matched_offset),
    .out_matched_length    (out_matched_length)
  );

  mhsm_checker result_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_entry_slot         (in_entry_slot),
    .in_byte_position      (in_byte_position),
    .in_pattern_byte       (in_pattern_byte),
    .in_mask_byte          (in_mask_byte),
    .in_pattern_length     (in_pattern_length),
    .in_start_offset       (in_start_offset),
    .in_confidence_level   (in_confidence_level),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_result_status     (out_result_status),
    .out_matched_entry     (out_matched_entry),
    .out_matched_confidence(out_matched_confidence),
    .out_matched_offset    (out_matched_offset),
    .out_matched_length    (out_matched_length),
    .mismatch_count        (mismatch_count),
    .pending_count         (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** masked_header_signature_matcher: FAILED **");
      $finish;
    end
  end

  function automatic cmd_t fresh_cmd(mhsm_pkg::op_t op);
    cmd_t c;
    c.op   = op;
    c.slot = 4'($urandom);
    c.pos  = 3'($urandom);
    c.pat  = 8'($urandom);
    c.mask = 8'($urandom);
    c.len  = 4'($urandom);
    c.offs = 8'($urandom);
    c.conf = 7'($urandom_range(0, 100));
    c.data = 8'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'hFF;
    if (r < 6) return 8'h00;
    return 8'($urandom);
  endfunction

  // Drives one item at the falling edge and holds it until the block takes it.
  task automatic send(cmd_t c);
    int gap, k, idx;
    gap = burst ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    in_opcode           = c.op;
    in_entry_slot       = c.slot;
    in_byte_position    = c.pos;
    in_pattern_byte     = c.pat;
    in_mask_byte        = c.mask;
    in_pattern_length   = c.len;
    in_start_offset     = c.offs;
    in_confidence_level = c.conf;
    in_data_byte        = c.data;
    in_last_byte        = c.last;
    start               = 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    case (c.op)
      mhsm_pkg::OP_CLEAR: m_count = 0;
      mhsm_pkg::OP_ADD: begin
        if (c.len != 0 && c.len <= PAT && m_count < SLOTS) begin
          m_len[m_count] = c.len;
          m_off[m_count] = c.offs;
          for (k = 0; k < PAT; k++) m_mask[m_count*PAT + k] = 8'hFF;
          m_count++;
        end
      end
      mhsm_pkg::OP_WRITE: begin
        idx            = int'(c.slot) * PAT + int'(c.pos);
        m_pat[idx]     = c.pat;
        m_mask[idx]    = c.mask;
        m_written[idx] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic wait_results_in();
    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Unwritten pattern bytes are still compared, with a mask of all ones, so every byte
  // inside the span of a live entry gets a value before header bytes are sent.
  task automatic fill_unwritten();
    int s, k;
    cmd_t c;
    for (s = 0; s < m_count; s++) begin
      for (k = 0; k < m_len[s]; k++) begin
        if (!m_written[s*PAT + k]) begin
          c      = fresh_cmd(mhsm_pkg::OP_WRITE);
          c.slot = 4'(s);
          c.pos  = 3'(k);
          c.mask = pick_mask();
          send(c);
        end
      end
    end
  endtask

  // Streams a header of hlen bytes that fits the target entry's masked pattern;
  // the lowest masked bit, if any, is flipped at bad_pos when it is in the span.
  task automatic stream_header(int target, int hlen, int bad_pos);
    cmd_t       c;
    int         p, idx;
    logic [7:0] m;
    for (p = 0; p < hlen; p++) begin
      c      = fresh_cmd(mhsm_pkg::OP_HEADER);
      c.last = (p == hlen - 1);
      if (target >= 0 && p >= m_off[target] && p < m_off[target] + m_len[target]) begin
        idx    = target * PAT + p - m_off[target];
        m      = m_mask[idx];
        c.data = (m_pat[idx] & m) | (c.data & ~m);
        if (p == bad_pos) c.data = c.data ^ (m & (~m + 8'd1));
      end
      send(c);
    end
  endtask

  task automatic random_header();
    int target, span_end, hlen, bad_pos;
    fill_unwritten();
    target  = -1;
    bad_pos = -1;
    hlen    = $urandom_range(1, 12);
    if (m_count > 0 && $urandom_range(0, 4) != 0) begin
      target   = $urandom_range(0, m_count - 1);
      span_end = m_off[target] + m_len[target];
      hlen     = span_end + $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0 && span_end > 1) hlen = span_end - 1;
      if ($urandom_range(0, 4) == 0) bad_pos = $urandom_range(m_off[target], span_end - 1);
    end
    stream_header(target, hlen, bad_pos);
  endtask

  task automatic build_table();
    int   n, r;
    cmd_t c;
    if ($urandom_range(0, 9) < 3) send(fresh_cmd(mhsm_pkg::OP_CLEAR));
    n = $urandom_range(1, 4);
    repeat (n) begin
      c = fresh_cmd(mhsm_pkg::OP_ADD);
      r = $urandom_range(0, 19);
      if (r == 0) c.len = 4'd0;
      else if (r == 1) c.len = 4'($urandom_range(9, 15));
      else c.len = 4'($urandom_range(1, 8));
      // Mostly short offsets keep headers short; a few reach the far end.
      if ($urandom_range(0, 39) != 0) c.offs = 8'($urandom_range(0, 12));
      if ($urandom_range(0, 3) == 0) c.conf = 7'd50;
      send(c);
    end
    if (m_count > 0) begin
      repeat ($urandom_range(0, 2)) begin
        c      = fresh_cmd(mhsm_pkg::OP_WRITE);
        c.slot = 4'($urandom_range(0, m_count - 1));
        c.mask = pick_mask();
        send(c);
      end
    end
  endtask

  task automatic noise_item();
    cmd_t c;
    c = fresh_cmd(mhsm_pkg::op_t'($urandom_range(0, 3)));
    if (c.op == mhsm_pkg::OP_ADD && $urandom_range(0, 39) != 0) begin
      c.offs = 8'($urandom_range(0, 12));
    end
    if (c.op == mhsm_pkg::OP_HEADER) fill_unwritten();
    send(c);
  endtask

  initial begin
    cmd_t c;
    int   i, k, phase, sel;
    m_count    = 0;
    items_sent = 0;
    burst      = 1'b0;
    for (i = 0; i < SLOTS*PAT; i++) begin
      m_pat[i]     = 8'h00;
      m_mask[i]    = 8'hFF;
      m_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: rejected lengths, adds at the field extremes, then a header
    // that matches two entries of equal confidence so the earlier one wins.
    c     = fresh_cmd(mhsm_pkg::OP_ADD);
    c.len = 4'd0;
    send(c);
    c     = fresh_cmd(mhsm_pkg::OP_ADD);
    c.len = 4'd15;
    send(c);
    for (i = 0; i < 3; i++) begin
      c      = fresh_cmd(mhsm_pkg::OP_ADD);
      c.len  = 4'(dir_len[i]);
      c.offs = 8'(dir_off[i]);
      c.conf = 7'(dir_conf[i]);
      send(c);
    end
    for (k = 0; k < 8; k++) begin
      c      = fresh_cmd(mhsm_pkg::OP_WRITE);
      c.slot = 4'd0;
      c.pos  = 3'(k);
      c.pat  = dir_pat[k];
      c.mask = dir_mask[k];
      send(c);
    end
    for (k = 0; k < 2; k++) begin
      c      = fresh_cmd(mhsm_pkg::OP_WRITE);
      c.slot = 4'd2;
      c.pos  = 3'(k);
      c.pat  = dir_pat[k+1];
      c.mask = dir_mask[k+1];
      send(c);
    end
    stream_header(0, 8, -1);
    // A one-byte header leaves every span incomplete.
    stream_header(-1, 1, -1);
    send(fresh_cmd(mhsm_pkg::OP_CLEAR));

    phase = 0;
    while (items_sent < ITEM_TARGET || phase <= 5) begin
      burst = ($urandom_range(0, 3) == 0);
      if (phase == 5) begin
        // Fill the table, then try one add too many.
        while (m_count < SLOTS) begin
          c      = fresh_cmd(mhsm_pkg::OP_ADD);
          c.len  = 4'($urandom_range(1, 8));
          c.offs = 8'($urandom_range(0, 12));
          send(c);
        end
        c     = fresh_cmd(mhsm_pkg::OP_ADD);
        c.len = 4'($urandom_range(1, 8));
        send(c);
        random_header();
      end else if (phase == 2) begin
        // Spans at the far end of the offset range; the header runs past the
        // point where the byte counter saturates.
        send(fresh_cmd(mhsm_pkg::OP_CLEAR));
        c      = fresh_cmd(mhsm_pkg::OP_ADD);
        c.len  = 4'd8;
        c.offs = 8'd255;
        c.conf = 7'd77;
        send(c);
        c      = fresh_cmd(mhsm_pkg::OP_ADD);
        c.len  = 4'd3;
        c.offs = 8'd250;
        c.conf = 7'd90;
        send(c);
        fill_unwritten();
        stream_header(0, 300, -1);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 3) build_table();
        else if (sel < 8) random_header();
        else repeat ($urandom_range(1, 3)) noise_item();
      end
      if (phase == 3 || $urandom_range(0, 15) == 0) wait_results_in();
      phase++;
    end

    wait_results_in();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** masked_header_signature_matcher: PASSED **");
    end else begin
      $display("** masked_header_signature_matcher: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mhsm_pkg.sv
design/mhsm_lane.sv
design/masked_header_signature_matcher.sv
sim/mhsm_checker.sv
sim/testbench.sv
